[rtl/ttip_pkg.sv]
// Package for the text-to-integer parser.
// Holds character codes, bases, classified-word type and parser state types.
// No dependencies.
`timescale 1ns / 1ps

package ttip_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  // Offsets that map letters onto digit values 10 and up.
  localparam logic [7:0] UP_OFS   = CH_UP_A - 8'd10;
  localparam logic [7:0] LO_OFS   = CH_LO_A - 8'd10;

  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_BIN  = 6'd2;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;

  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  // One character after classification by the front end.
  typedef struct packed {
    logic       space;
    logic       minus;
    logic       plus;
    logic       zero;
    logic       xch;
    logic       bch;
    logic       dig_ok;
    logic [5:0] dig;
  } cls_t;

  typedef enum logic [3:0] {
    PH_SKIP   = 4'b0001,
    PH_SIGNED = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    DS_NONE = 2'b00,
    DS_SEEN = 2'b01,
    DS_OVER = 2'b10
  } dstat_t;

endpackage

[rtl/ttip_front.sv]
// Front end of the text-to-integer parser: classifies one raw character.
// Depends on ttip_pkg.
`timescale 1ns / 1ps

module ttip_front
  import ttip_pkg::*;
(
  input  logic [7:0] ch,
  output cls_t       word
);

  always_comb begin
    word        = '0;
    word.space  = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF);
    word.minus  = (ch == CH_MINUS);
    word.plus   = (ch == CH_PLUS);
    word.zero   = (ch == CH_ZERO);
    word.xch    = (ch == CH_LO_X) || (ch == CH_UP_X);
    word.bch    = (ch == CH_LO_B) || (ch == CH_UP_B);
    if (ch inside {[CH_ZERO:CH_NINE]}) begin
      word.dig_ok = 1'b1;
      word.dig    = 6'(ch - CH_ZERO);
    end else if (ch inside {[CH_UP_A:CH_UP_Z]}) begin
      word.dig_ok = 1'b1;
      word.dig    = 6'(ch - UP_OFS);
    end else if (ch inside {[CH_LO_A:CH_LO_Z]}) begin
      word.dig_ok = 1'b1;
      word.dig    = 6'(ch - LO_OFS);
    end
  end

endmodule

[rtl/ttip_queue.sv]
// Short queue of classified words between front and back of the parser.
// Depends on ttip_pkg.
`timescale 1ns / 1ps

module ttip_queue
  import ttip_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t push_word,
  output logic full,
  output logic q_valid,
  output cls_t q_word,
  input  logic pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cls_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_word  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/ttip_back.sv]
// Back end of the text-to-integer parser: parse state, digit accumulation
// with overflow detection, and the result register. Depends on ttip_pkg.
`timescale 1ns / 1ps

module ttip_back
  import ttip_pkg::*;
#(
  parameter int OFFSET_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [5:0]             number_base,
  input  logic                   q_valid,
  input  cls_t                   q_word,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [63:0]     value,
  output logic [OFFSET_BITS-1:0] end_offset,
  output logic                   converted,
  output logic                   overflow
);

  phase_t                 phase, phase_next;
  logic                   negative, negative_next;
  logic [5:0]             active_base, active_base_next;
  logic [63:0]            acc, acc_next;
  dstat_t                 status, status_next;
  logic [OFFSET_BITS-1:0] count, count_next;

  logic       take;
  logic [5:0] t_ab;
  dstat_t     t_st;
  logic [5:0] base_eff;
  logic [69:0] prod;
  logic [70:0] sum;
  logic [63:0] limit;
  logic       dig_fits;
  logic       ovf;
  logic       fin;
  logic       slot_free;
  logic       advance;
  logic [63:0] fin_value;

  // Phase decode: choose whether this word is a digit candidate and with
  // which base and status it enters the accumulator.
  always_comb begin
    take             = 1'b0;
    t_ab             = active_base;
    t_st             = status;
    phase_next       = phase;
    negative_next    = negative;
    active_base_next = active_base;
    case (phase)
      PH_SIGNED: begin
        if (q_word.zero && (active_base == BASE_AUTO || active_base == BASE_HEX ||
                            active_base == BASE_BIN)) begin
          phase_next = PH_ZERO;
        end else begin
          take = 1'b1;
          t_ab = (active_base == BASE_AUTO) ? BASE_DEC : active_base;
        end
      end
      PH_ZERO: begin
        if (q_word.xch && (active_base == BASE_AUTO || active_base == BASE_HEX)) begin
          active_base_next = BASE_HEX;
          phase_next       = PH_DIGITS;
        end else if (q_word.bch &&
                     (active_base == BASE_AUTO || active_base == BASE_BIN)) begin
          active_base_next = BASE_BIN;
          phase_next       = PH_DIGITS;
        end else begin
          // The leading zero counts as a digit; the accumulator stays zero.
          take = 1'b1;
          t_ab = (active_base == BASE_AUTO) ? BASE_OCT : active_base;
          t_st = DS_SEEN;
        end
      end
      PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
        phase_next = PH_SKIP;
        if (!q_word.space) begin
          active_base_next = number_base;
          if (q_word.minus) begin
            negative_next = 1'b1;
            phase_next    = PH_SIGNED;
          end else if (q_word.plus) begin
            phase_next = PH_SIGNED;
          end else if (q_word.zero && (number_base == BASE_AUTO ||
                       number_base == BASE_HEX || number_base == BASE_BIN)) begin
            phase_next = PH_ZERO;
          end else begin
            take = 1'b1;
            t_ab = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
          end
        end
      end
    endcase
  end

  // Accumulate: overflow when acc * base + digit exceeds the signed limit.
  always_comb begin
    base_eff = (t_ab == BASE_AUTO) ? BASE_DEC : t_ab;
    prod     = {6'b0, acc} * {64'b0, base_eff};
    sum      = {1'b0, prod} + 71'(q_word.dig);
    limit    = negative ? NEG_LIMIT : POS_LIMIT;
    dig_fits = q_word.dig_ok && (q_word.dig < base_eff);
    ovf      = (t_st == DS_OVER) || (sum > {7'b0, limit});
    fin      = take && !dig_fits;
    if (t_st == DS_OVER) begin
      fin_value = negative ? NEG_LIMIT : POS_LIMIT;
    end else begin
      fin_value = negative ? (64'd0 - acc) : acc;
    end
  end

  always_comb begin
    acc_next    = acc;
    status_next = status;
    count_next  = (count == '1) ? count : count + 1'b1;
    if (fin) begin
      acc_next    = '0;
      status_next = DS_NONE;
      count_next  = '0;
    end else if (take) begin
      status_next = ovf ? DS_OVER : DS_SEEN;
      acc_next    = ovf ? acc : sum[63:0];
    end
  end

  assign slot_free = !out_valid || !out_stall;
  assign advance   = q_valid && (!fin || slot_free);
  assign q_pop     = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SKIP;
      negative    <= 1'b0;
      active_base <= BASE_AUTO;
      acc         <= '0;
      status      <= DS_NONE;
      count       <= '0;
    end else if (advance) begin
      count  <= count_next;
      acc    <= acc_next;
      status <= status_next;
      if (fin) begin
        phase       <= PH_SKIP;
        negative    <= 1'b0;
        active_base <= BASE_AUTO;
      end else if (take) begin
        phase       <= PH_DIGITS;
        negative    <= negative_next;
        active_base <= t_ab;
      end else begin
        phase       <= phase_next;
        negative    <= negative_next;
        active_base <= active_base_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fin) begin
      value      <= signed'(fin_value);
      converted  <= (t_st != DS_NONE);
      overflow   <= (t_st == DS_OVER);
      end_offset <= (t_st != DS_NONE) ? count : '0;
    end
  end

  a_skip_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP) |-> (acc == '0 && status == DS_NONE && !negative))
    else $error("parser idle with stale accumulator or status");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |->
      (converted && (value == signed'(POS_LIMIT) || value == signed'(NEG_LIMIT))))
    else $error("overflowed result is not saturated");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !converted) |-> (value == 64'sd0 && end_offset == '0))
    else $error("result without conversion is not zero");

  a_fin_resets: assert property (@(posedge clk) disable iff (rst)
    (q_valid && advance && fin) |=> (phase == PH_SKIP && count == '0))
    else $error("parse state not cleared after a result");

endmodule

[rtl/text_to_integer_parser.sv]
// Top level of the streaming text-to-integer parser (signed 64-bit).
// Depends on ttip_pkg, ttip_front, ttip_queue and ttip_back.
//
// Usage: characters enter on ch with in_valid/in_stall, one word per cycle.
// Leading space, tab and LF are skipped, an optional sign follows, then the
// digits in the base held by the number_base register (0 detects 0x, 0b,
// leading-zero octal or decimal). The first character that cannot continue
// the number produces one result word on value, end_offset, converted and
// overflow with out_valid/out_stall; all other characters produce none.
// Throughput is one character per cycle while in_stall is low; the digit step in the
// back end is one 64x6 multiply, add and limit compare. A terminating character
// passes through the queue, and its result is then registered on the outputs.
// A four-word queue separates the classifying front from the back end, so
// the input keeps flowing while a result waits; when the receiver stalls,
// the back end halts only at the next terminating character, and in_stall
// rises once the queue is full.
// Reset clears the parse state, the queue, out_valid and number_base (0).
// The user writes number_base via cfg_write/cfg_data only while the block is idle; it is not enforced.
`timescale 1ns / 1ps

module text_to_integer_parser
  import ttip_pkg::*;
#(
  parameter int OFFSET_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [5:0]             cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             ch,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [63:0]     value,
  output logic [OFFSET_BITS-1:0] end_offset,
  output logic                   converted,
  output logic                   overflow
);

  logic [5:0] number_base;
  cls_t       in_word;
  cls_t       q_word;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_AUTO;
    end else if (cfg_write) begin
      number_base <= cfg_data;
    end
  end

  assign in_stall = q_full;

  ttip_front u_front (
    .ch   (ch),
    .word (in_word)
  );

  ttip_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_word (in_word),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .pop       (q_pop)
  );

  ttip_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .number_base (number_base),
    .q_valid     (q_valid),
    .q_word      (q_word),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .end_offset  (end_offset),
    .converted   (converted),
    .overflow    (overflow)
  );

endmodule

[verif/tb_top.sv]
// Self-checking testbench for text_to_integer_parser.
// Drives character words with random gaps, predicts each parsed number in a
// local model of the parser and checks every result word. Needs ttip_pkg.
`timescale 1ns / 1ps

module tb_top
  import ttip_pkg::*;
();

  localparam int OFFSET_BITS = 12;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
  localparam int CYCLE_LIMIT = 100000;
  localparam int NUM_PHASES = 11;
  localparam int PHASE_CHARS = 145;
  localparam int HOLD_PHASE = 2;
  localparam int CALM_PHASE = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic signed [63:0]     value;
    logic [OFFSET_BITS-1:0] end_offset;
    logic                   converted;
    logic                   overflow;
  } parse_result_t;

  localparam parse_result_t NO_NUMBER = '0;

  typedef struct {
    logic [7:0]    c;
    bit            typed;
    parse_result_t want;
  } drive_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [5:0]             cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             ch = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [63:0]     value;
  logic [OFFSET_BITS-1:0] end_offset;
  logic                   converted;
  logic                   overflow;

  // Local copy of the parser state and the base register.
  phase_t                 ps_phase = PH_SKIP;
  logic                   ps_neg = 1'b0;
  logic [5:0]             ps_base = BASE_AUTO;
  logic [63:0]            ps_acc = '0;
  dstat_t                 ps_stat = DS_NONE;
  logic [OFFSET_BITS-1:0] ps_count = '0;
  logic [5:0]             base_reg = BASE_AUTO;

  parse_result_t pending_results[$];
  parse_result_t want_now;
  logic [7:0]    text_chars[$];
  int            errors = 0;
  int            cycle_count = 0;
  bit            calm = 1'b0;
  bit            hold_pending = 1'b0;
  bit            hold_taken = 1'b0;
  int            hold_left = 0;

  // Typed rows end a string with no digit at all, so the result is all zero.
  drive_row_t opening_text [24] = '{
    '{8'h00,    1'b1, NO_NUMBER},
    '{CH_SPACE, 1'b0, NO_NUMBER},
    '{CH_TAB,   1'b0, NO_NUMBER},
    '{CH_LF,    1'b0, NO_NUMBER},
    '{CH_MINUS, 1'b0, NO_NUMBER},
    '{CH_ZERO,  1'b0, NO_NUMBER},
    '{CH_LO_X,  1'b0, NO_NUMBER},
    '{"f",      1'b0, NO_NUMBER},
    '{"F",      1'b0, NO_NUMBER},
    '{8'hFF,    1'b0, NO_NUMBER},
    '{CH_ZERO,  1'b0, NO_NUMBER},
    '{CH_LO_B,  1'b0, NO_NUMBER},
    '{"1",      1'b0, NO_NUMBER},
    '{CH_ZERO,  1'b0, NO_NUMBER},
    '{"2",      1'b0, NO_NUMBER},
    '{CH_ZERO,  1'b0, NO_NUMBER},
    '{"7",      1'b0, NO_NUMBER},
    '{"8",      1'b0, NO_NUMBER},
    '{CH_PLUS,  1'b0, NO_NUMBER},
    '{"!",      1'b1, NO_NUMBER},
    '{CH_ZERO,  1'b0, NO_NUMBER},
    '{CH_UP_X,  1'b0, NO_NUMBER},
    '{"g",      1'b1, NO_NUMBER},
    '{"z",      1'b1, NO_NUMBER}
  };

  logic [5:0] base_plan [NUM_PHASES] = '{
    6'd63, 6'd1, BASE_AUTO, 6'd36, BASE_HEX, BASE_BIN,
    BASE_OCT, BASE_DEC, 6'd37, BASE_AUTO, BASE_AUTO
  };

  text_to_integer_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .ch(ch),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value(value),
    .end_offset(end_offset),
    .converted(converted),
    .overflow(overflow)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("text_to_integer_parser test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic int digit_of(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_UP_A && c <= CH_UP_Z) return int'(c - UP_OFS);
    if (c >= CH_LO_A && c <= CH_LO_Z) return int'(c - LO_OFS);
    return 255;
  endfunction

  function automatic logic [63:0] radix();
    return (ps_base != BASE_AUTO) ? 64'(ps_base) : 64'(BASE_DEC);
  endfunction

  function automatic void clear_number();
    ps_phase = PH_SKIP;
    ps_neg = 1'b0;
    ps_base = BASE_AUTO;
    ps_acc = '0;
    ps_stat = DS_NONE;
    ps_count = '0;
  endfunction

  function automatic parse_result_t close_number();
    parse_result_t r;
    if (ps_stat == DS_OVER) r.value = ps_neg ? NEG_LIMIT : POS_LIMIT;
    else r.value = ps_neg ? -ps_acc : ps_acc;
    r.end_offset = (ps_stat != DS_NONE) ? ps_count : '0;
    r.converted = (ps_stat != DS_NONE);
    r.overflow = (ps_stat == DS_OVER);
    clear_number();
    return r;
  endfunction

  // Saturation test uses the exact bound for the sign: cutoff and remainder.
  function automatic void add_digit(input int d);
    logic [63:0] b, limit, cutoff, cutlim;
    b = radix();
    limit = ps_neg ? NEG_LIMIT : POS_LIMIT;
    cutoff = limit / b;
    cutlim = limit % b;
    if (ps_stat == DS_OVER || ps_acc > cutoff || (ps_acc == cutoff && 64'(d) > cutlim)) begin
      ps_stat = DS_OVER;
    end else begin
      ps_stat = DS_SEEN;
      ps_acc = ps_acc * b + 64'(d);
    end
  endfunction

  function automatic bit take_digit(input logic [7:0] c, output parse_result_t r);
    int d;
    d = digit_of(c);
    if (64'(d) >= radix()) begin
      r = close_number();
      return 1'b1;
    end
    add_digit(d);
    ps_phase = PH_DIGITS;
    return 1'b0;
  endfunction

  function automatic bit start_number(input logic [7:0] c, output parse_result_t r);
    if (c == CH_ZERO && (ps_base == BASE_AUTO || ps_base == BASE_HEX || ps_base == BASE_BIN))
    begin
      ps_phase = PH_ZERO;
      return 1'b0;
    end
    if (ps_base == BASE_AUTO) ps_base = BASE_DEC;
    return take_digit(c, r);
  endfunction

  // Advances the local parser by one character; returns 1 when it ends a number.
  function automatic bit parse_char(input logic [7:0] c, output parse_result_t r);
    bit done;
    done = 1'b0;
    case (ps_phase)
      PH_SIGNED: begin
        done = start_number(c, r);
      end
      PH_ZERO: begin
        if ((c == CH_LO_X || c == CH_UP_X) && (ps_base == BASE_AUTO || ps_base == BASE_HEX))
        begin
          ps_base = BASE_HEX;
          ps_phase = PH_DIGITS;
        end else if ((c == CH_LO_B || c == CH_UP_B) &&
                     (ps_base == BASE_AUTO || ps_base == BASE_BIN)) begin
          ps_base = BASE_BIN;
          ps_phase = PH_DIGITS;
        end else begin
          if (ps_base == BASE_AUTO) ps_base = BASE_OCT;
          add_digit(0);
          done = take_digit(c, r);
        end
      end
      PH_DIGITS: begin
        done = take_digit(c, r);
      end
      default: begin
        ps_phase = PH_SKIP;
        if (c != CH_SPACE && c != CH_TAB && c != CH_LF) begin
          ps_base = base_reg;
          if (c == CH_MINUS) begin
            ps_neg = 1'b1;
            ps_phase = PH_SIGNED;
          end else if (c == CH_PLUS) begin
            ps_phase = PH_SIGNED;
          end else begin
            done = start_number(c, r);
          end
        end
      end
    endcase
    if (!done && ps_count != OFFSET_MAX) ps_count++;
    return done;
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic logic [7:0] digit_char(input int v);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(1) ? CH_UP_A : CH_LO_A) + 8'(v - 10);
  endfunction

  // Appends one string: noise bytes, or optional whitespace, sign, prefix, digits and a terminator.
  task automatic gen_number(input logic [5:0] cfg);
    int unsigned kind, n, b, lim;
    logic [63:0] mag;
    logic [7:0] digs[$];
    kind = $urandom_range(99);
    if (kind < 12) begin
      // Noise: raw bytes of any value.
      n = $urandom_range(1, 6);
      repeat (n) text_chars.push_back(8'($urandom));
      return;
    end
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) begin
      case ($urandom_range(2))
        0: text_chars.push_back(CH_SPACE);
        1: text_chars.push_back(CH_TAB);
        default: text_chars.push_back(CH_LF);
      endcase
    end
    case ($urandom_range(5))
      0: text_chars.push_back(CH_MINUS);
      1: text_chars.push_back(CH_PLUS);
      default: ;
    endcase
    b = 32'(cfg);
    if (cfg == BASE_AUTO) begin
      case ($urandom_range(3))
        0: begin
          text_chars.push_back(CH_ZERO);
          text_chars.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
          b = 32'(BASE_HEX);
        end
        1: begin
          text_chars.push_back(CH_ZERO);
          text_chars.push_back($urandom_range(1) ? CH_LO_B : CH_UP_B);
          b = 32'(BASE_BIN);
        end
        2: begin
          text_chars.push_back(CH_ZERO);
          b = 32'(BASE_OCT);
        end
        default: b = 32'(BASE_DEC);
      endcase
    end else if (cfg == BASE_HEX && $urandom_range(2) == 0) begin
      text_chars.push_back(CH_ZERO);
      text_chars.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
    end else if (cfg == BASE_BIN && $urandom_range(2) == 0) begin
      text_chars.push_back(CH_ZERO);
      text_chars.push_back($urandom_range(1) ? CH_LO_B : CH_UP_B);
    end
    if (kind < 20) begin
      // Broken string: no digit after the sign or prefix.
    end else if (b >= 2 && b <= 36 && kind < 50) begin
      case ($urandom_range(5))
        0: mag = POS_LIMIT;
        1: mag = POS_LIMIT + 64'd1;
        2: mag = POS_LIMIT + 64'd2;
        3: mag = {$urandom, $urandom};
        4: mag = 64'($urandom_range(999));
        default: mag = {$urandom, $urandom} >> $urandom_range(63);
      endcase
      do begin
        digs.push_front(digit_char(int'(mag % 64'(b))));
        mag = mag / 64'(b);
      end while (mag != 0);
      foreach (digs[i]) text_chars.push_back(digs[i]);
    end else begin
      lim = (b > 36) ? 36 : b;
      n = ($urandom_range(4) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      repeat (n) text_chars.push_back(digit_char($urandom_range(lim - 1)));
    end
    case ($urandom_range(3))
      0: text_chars.push_back(8'h00);
      1: text_chars.push_back(",");
      2: text_chars.push_back(CH_SPACE);
      default: text_chars.push_back(8'($urandom));
    endcase
  endtask

  task automatic send_char(input logic [7:0] c);
    if (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text();
    parse_result_t r;
    logic [7:0] c;
    while (text_chars.size() != 0) begin
      c = text_chars.pop_front();
      send_char(c);
      if (parse_char(c, r)) pending_results.push_back(r);
    end
  endtask

  // Waits until every expected word has come, then lets the input queue drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [5:0] b);
    cfg_write <= 1'b1;
    cfg_data <= b;
    @(posedge clk);
    cfg_write <= 1'b0;
    base_reg = b;
  endtask

  // -------------------------------------------------------------- checker

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected: value %0d offset %0d",
                 $time, value, end_offset);
        errors++;
      end else begin
        want_now = pending_results.pop_front();
        if (value !== want_now.value) begin
          $display("%0t: value expected %0d actual %0d", $time, want_now.value, value);
          errors++;
        end
        if (end_offset !== want_now.end_offset) begin
          $display("%0t: end_offset expected %0d actual %0d",
                   $time, want_now.end_offset, end_offset);
          errors++;
        end
        if (converted !== want_now.converted) begin
          $display("%0t: converted expected %0b actual %0b",
                   $time, want_now.converted, converted);
          errors++;
        end
        if (overflow !== want_now.overflow) begin
          $display("%0t: overflow expected %0b actual %0b",
                   $time, want_now.overflow, overflow);
          errors++;
        end
      end
    end
  end

  // Receiver side: random stalls, and once a long hold while the sender keeps going.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_pending && !hold_taken) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 19);
    end
  end

  // ----------------------------------------------------------------- main

  initial begin
    parse_result_t r;
    bit got;
    int sent;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_text[i]) begin
      send_char(opening_text[i].c);
      got = parse_char(opening_text[i].c, r);
      if (opening_text[i].typed) pending_results.push_back(opening_text[i].want);
      else if (got) pending_results.push_back(r);
    end

    base_plan[9] = 6'($urandom_range(63));
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_base(base_plan[ph]);
      calm = (ph == CALM_PHASE);
      if (ph == HOLD_PHASE) hold_pending = 1'b1;
      sent = 0;
      while (sent < PHASE_CHARS) begin
        gen_number(base_reg);
        sent += text_chars.size();
        send_text();
      end
      // Sometimes leave a number open so the next base write lands mid-string.
      if ($urandom_range(1)) begin
        if ($urandom_range(1)) text_chars.push_back(CH_MINUS);
        text_chars.push_back("1");
        send_text();
      end
    end
    calm = 1'b0;
    settle();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("text_to_integer_parser test passed");
    end else begin
      $display("text_to_integer_parser test failed");
    end
    $finish;
  end

endmodule

[text_to_integer_parser.f]
rtl/ttip_pkg.sv
rtl/ttip_front.sv
rtl/ttip_queue.sv
rtl/ttip_back.sv
rtl/text_to_integer_parser.sv
verif/tb_top.sv
